>>> hdl/filled_circle_span_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Filled circle span rasterizer assertion macros
// Concurrent assertion wrappers used by the controller RTL. They compile to
// nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef FILLED_CIRCLE_SPAN_RASTERIZER_ASSERT_SVH
`define FILLED_CIRCLE_SPAN_RASTERIZER_ASSERT_SVH

`ifndef ASSERT_OFF
`define FCSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FCSR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCSR_ASSERT(label, prop, msg)
`define FCSR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> hdl/fcsr_pkg.sv
// ----------------------------------------------------------------------------
// Filled circle span rasterizer package
// Widths, limits and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsr_pkg;

  localparam int COORD_W = 16;
  localparam int EDGE_W  = 17;
  localparam int RAD_W   = 6;
  localparam int STEP_W  = 7;
  localparam int SIZE_W  = 7;
  localparam int SQ_W    = 12;
  localparam int SUM_W   = 13;

  localparam int MAX_RESULTS = 46;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  localparam logic [RAD_W-1:0] MAX_RADIUS = 6'd63;

  typedef struct packed {
    logic load;
    logic square;
    logic step_down;
    logic emit;
  } fcsr_cmd_t;

  typedef struct packed {
    logic step_down_ok;
    logic last;
  } fcsr_sts_t;

endpackage

`default_nettype wire

>>> hdl/fcsr_datapath.sv
// ----------------------------------------------------------------------------
// Filled circle span rasterizer datapath
// Holds the center, the octant position and the running sum x*x + y*y, and
// registers each rectangle pair as it is emitted.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsr_datapath import fcsr_pkg::*; (
  input  wire                           clk,
  input  wire                           rst,
  input  wire  fcsr_cmd_t               cmd,
  output fcsr_sts_t                     sts,
  input  wire  signed [COORD_W-1:0]     center_x,
  input  wire  signed [COORD_W-1:0]     center_y,
  input  wire         [RAD_W-1:0]       radius,
  output logic signed [EDGE_W-1:0]      wide_left,
  output logic signed [EDGE_W-1:0]      wide_top,
  output logic        [SIZE_W-1:0]      wide_width,
  output logic        [SIZE_W-1:0]      wide_height,
  output logic signed [EDGE_W-1:0]      tall_left,
  output logic signed [EDGE_W-1:0]      tall_top,
  output logic        [SIZE_W-1:0]      tall_width,
  output logic        [SIZE_W-1:0]      tall_height,
  output logic                          last_pair
);

  logic [COORD_W-1:0] held_cx;
  logic [COORD_W-1:0] held_cy;
  logic [RAD_W-1:0]   rad;
  logic [STEP_W-1:0]  step_x;
  logic [STEP_W-1:0]  step_y;
  logic [SQ_W-1:0]    radius_squared;
  logic [SUM_W-1:0]   sum_sq;
  logic [CNT_W-1:0]   count;

  logic [RAD_W-1:0]   rad_clamped;
  logic [SQ_W-1:0]    rad_product;
  logic [EDGE_W-1:0]  cx_ext;
  logic [EDGE_W-1:0]  cy_ext;
  logic [EDGE_W-1:0]  x_ext;
  logic [EDGE_W-1:0]  y_ext;

  assign rad_clamped = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
  assign rad_product = SQ_W'(rad) * SQ_W'(rad);

  assign cx_ext = {held_cx[COORD_W-1], held_cx};
  assign cy_ext = {held_cy[COORD_W-1], held_cy};
  assign x_ext  = {{(EDGE_W-STEP_W){1'b0}}, step_x};
  assign y_ext  = {{(EDGE_W-STEP_W){1'b0}}, step_y};

  assign sts.step_down_ok = (step_y != '0) && (sum_sq >= {1'b0, radius_squared});
  assign sts.last         = (step_y < step_x) || (count == CNT_W'(MAX_RESULTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      held_cx        <= '0;
      held_cy        <= '0;
      rad            <= '0;
      step_x         <= '0;
      step_y         <= '0;
      radius_squared <= '0;
      sum_sq         <= '0;
      count          <= '0;
      wide_left      <= '0;
      wide_top       <= '0;
      wide_width     <= '0;
      wide_height    <= '0;
      tall_left      <= '0;
      tall_top       <= '0;
      tall_width     <= '0;
      tall_height    <= '0;
      last_pair      <= 1'b0;
    end else begin
      if (cmd.load) begin
        held_cx <= center_x;
        held_cy <= center_y;
        rad     <= rad_clamped;
        step_x  <= '0;
        step_y  <= {1'b0, rad_clamped};
        count   <= '0;
      end
      if (cmd.square) begin
        radius_squared <= rad_product;
        sum_sq         <= {1'b0, rad_product};
      end
      if (cmd.step_down) begin
        step_y <= step_y - STEP_W'(1);
        sum_sq <= sum_sq - ({{(SUM_W-STEP_W-1){1'b0}}, step_y, 1'b0} - SUM_W'(1));
      end
      if (cmd.emit) begin
        wide_left   <= cx_ext - x_ext;
        wide_top    <= cy_ext - y_ext;
        wide_width  <= {step_x[STEP_W-2:0], 1'b0};
        wide_height <= {step_y[STEP_W-2:0], 1'b0};
        tall_left   <= cx_ext - y_ext;
        tall_top    <= cy_ext - x_ext;
        tall_width  <= {step_y[STEP_W-2:0], 1'b0};
        tall_height <= {step_x[STEP_W-2:0], 1'b0};
        last_pair   <= sts.last;
        count       <= count + CNT_W'(1);
        step_x      <= step_x + STEP_W'(1);
        sum_sq      <= sum_sq + {{(SUM_W-STEP_W-1){1'b0}}, step_x, 1'b1};
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/fcsr_ctrl.sv
// ----------------------------------------------------------------------------
// Filled circle span rasterizer controller
// Sequences load, squaring of the radius and the octant walk, and drives the
// busy flag and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
`include "filled_circle_span_rasterizer_assert.svh"

module fcsr_ctrl import fcsr_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  input  wire fcsr_sts_t sts,
  output fcsr_cmd_t  cmd,
  output logic       busy,
  output logic       strobe
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_WALK
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (sts.step_down_ok) begin
          cmd.step_down = 1'b1;
        end else begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      busy   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      busy   <= (state_next != ST_IDLE);
      strobe <= cmd.emit;
    end
  end

  `FCSR_ASSERT(a_accept_sets_busy, (start && !busy) |=> busy, "accepted start did not raise busy")
  `FCSR_ASSERT(a_strobe_from_walk, strobe |-> $past(state == ST_WALK), "strobe outside the walk")
  `FCSR_ASSERT(a_last_ends_walk, (cmd.emit && sts.last) |=> (!busy && strobe), "last pair did not end the walk")
  `FCSR_ASSERT(a_busy_tracks_state, busy == (state != ST_IDLE), "busy disagrees with state")
  `FCSR_ASSERT_ALWAYS(a_reset_clears_flags, rst |=> (!busy && !strobe), "reset left busy or strobe set")

endmodule

`default_nettype wire

>>> hdl/filled_circle_span_rasterizer.sv
// ----------------------------------------------------------------------------
// Filled circle span rasterizer
// Fills a circle with pairs of centered rectangles found by walking one octant.
//
//   Channel  Handshake            Beat contents
//   input    start, busy          center_x, center_y, radius
//   result   strobe               wide_*, tall_*, last_pair
//
// A circle takes a load and a squaring step, then one walk step for each
// rectangle pair and each lowering of y; at radius 63 that is 46 pairs and
// 19 steps. The single running-sum register for x*x + y*y sets this: it moves
// one step per cycle. Reset is synchronous on rst and returns the block to
// idle. Each result beat stands for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module filled_circle_span_rasterizer import fcsr_pkg::*; (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  output logic                       busy,
  input  wire  signed [COORD_W-1:0]  center_x,
  input  wire  signed [COORD_W-1:0]  center_y,
  input  wire         [RAD_W-1:0]    radius,
  output logic                       strobe,
  output logic signed [EDGE_W-1:0]   wide_left,
  output logic signed [EDGE_W-1:0]   wide_top,
  output logic        [SIZE_W-1:0]   wide_width,
  output logic        [SIZE_W-1:0]   wide_height,
  output logic signed [EDGE_W-1:0]   tall_left,
  output logic signed [EDGE_W-1:0]   tall_top,
  output logic        [SIZE_W-1:0]   tall_width,
  output logic        [SIZE_W-1:0]   tall_height,
  output logic                       last_pair
);

  fcsr_cmd_t cmd;
  fcsr_sts_t sts;

  fcsr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  fcsr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius      (radius),
    .wide_left   (wide_left),
    .wide_top    (wide_top),
    .wide_width  (wide_width),
    .wide_height (wide_height),
    .tall_left   (tall_left),
    .tall_top    (tall_top),
    .tall_width  (tall_width),
    .tall_height (tall_height),
    .last_pair   (last_pair)
  );

endmodule

`default_nettype wire
